// File: rtl/segment_overlap_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment overlap rasterizer
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_OVERLAP_RASTERIZER_CORE_ASSERT_SVH
`define SEGMENT_OVERLAP_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTH
// condition must never be true outside reset
`define SOR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sor assertion failed");
// antecedent implies consequent in the same cycle
`define SOR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sor assertion failed");
`else
`define SOR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define SOR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg
// Shared types and constants of the segment overlap rasterizer.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int CoordW = 10;
  localparam int CountW = 11;
  localparam int TotalW = 21;
  localparam int HitW   = 2;

  localparam logic [HitW-1:0]   HIT_ONE   = 2'd1;
  localparam logic [HitW-1:0]   HIT_SAT   = 2'd2;
  localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [TotalW-1:0] total_t;

  // per-cell coordinate step
  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_INC,
    STEP_DEC
  } step_e;

  // raw segment word as taken from the input ports
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  // classified segment: first cell, step per cell, cell count
  typedef struct packed {
    coord_t x;
    coord_t y;
    step_e  step_x;
    step_e  step_y;
    count_t count;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } back_state_e;

endpackage

// File: rtl/sor_fifo.sv
// ----------------------------------------------------------------------------
// sor_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sor_fifo #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/sor_front.sv
// ----------------------------------------------------------------------------
// sor_front
// Input stage: registers a segment word and classifies it into a command.
// ----------------------------------------------------------------------------
module sor_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sor_pkg::seg_t seg_i,
  input  logic          hold_i,
  output logic          full_o,
  output logic          cmd_push_o,
  output sor_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);

  sor_pkg::seg_t  raw_q;
  logic           raw_v_q, raw_v_d;
  logic           accept;

  sor_pkg::coord_t lo_y, hi_y, lo_x, hi_x;
  sor_pkg::coord_t xs, ys, xe, ye, dx, dy, dmin;

  // accept while not held and the holding register is free or drains this cycle
  assign full_o     = hold_i || (raw_v_q && cmd_full_i);
  assign accept     = push_i && !full_o;
  assign cmd_push_o = raw_v_q && !cmd_full_i;

  always_comb begin
    raw_v_d = raw_v_q;
    if (cmd_push_o) begin
      raw_v_d = 1'b0;
    end
    if (accept) begin
      raw_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_v_q <= 1'b0;
    end else begin
      raw_v_q <= raw_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= seg_i;
    end
  end

  // orderings for straight segments, start/end for diagonals
  always_comb begin
    lo_y = (raw_q.sy < raw_q.ey) ? raw_q.sy : raw_q.ey;
    hi_y = (raw_q.sy < raw_q.ey) ? raw_q.ey : raw_q.sy;
    lo_x = (raw_q.sx < raw_q.ex) ? raw_q.sx : raw_q.ex;
    hi_x = (raw_q.sx < raw_q.ex) ? raw_q.ex : raw_q.sx;
    if (raw_q.sy > raw_q.ey) begin
      xs = raw_q.sx;
      ys = raw_q.sy;
      xe = raw_q.ex;
      ye = raw_q.ey;
    end else begin
      xs = raw_q.ex;
      ys = raw_q.ey;
      xe = raw_q.sx;
      ye = raw_q.sy;
    end
    dx   = (xe > xs) ? (xe - xs) : (xs - xe);
    dy   = ys - ye;
    dmin = (dx < dy) ? dx : dy;
  end

  // classify: vertical, horizontal, else diagonal walking y down
  always_comb begin
    if (raw_q.sx == raw_q.ex) begin
      cmd_o.x      = raw_q.sx;
      cmd_o.y      = lo_y;
      cmd_o.step_x = sor_pkg::STEP_HOLD;
      cmd_o.step_y = sor_pkg::STEP_INC;
      cmd_o.count  = {1'b0, hi_y} - {1'b0, lo_y} + sor_pkg::CountW'(1);
    end else if (raw_q.sy == raw_q.ey) begin
      cmd_o.x      = lo_x;
      cmd_o.y      = raw_q.sy;
      cmd_o.step_x = sor_pkg::STEP_INC;
      cmd_o.step_y = sor_pkg::STEP_HOLD;
      cmd_o.count  = {1'b0, hi_x} - {1'b0, lo_x} + sor_pkg::CountW'(1);
    end else begin
      cmd_o.x      = xs;
      cmd_o.y      = ys;
      cmd_o.step_x = (xe > xs) ? sor_pkg::STEP_INC : sor_pkg::STEP_DEC;
      cmd_o.step_y = sor_pkg::STEP_DEC;
      cmd_o.count  = {1'b0, dmin} + sor_pkg::CountW'(1);
    end
  end

endmodule

// File: rtl/sor_back.sv
// ----------------------------------------------------------------------------
// sor_back
// Cell walker: one hit-count read-modify-write per cycle while walking, running total.
// ----------------------------------------------------------------------------
module sor_back #(
  parameter int GRID_SIDE = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sor_pkg::cmd_t   cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output sor_pkg::total_t res_total_o,
  output logic            clearing_o
);

  // coordinates never exceed the input width, so the store is capped there
  localparam int CoordSpan = 1 << sor_pkg::CoordW;
  localparam int SideEff   = (GRID_SIDE < CoordSpan) ? GRID_SIDE : CoordSpan;
  localparam int AW        = $clog2(SideEff);
  localparam int AddrW     = 2 * AW;
  localparam int Depth     = 1 << AddrW;

  sor_pkg::back_state_e state_q, state_d;

  sor_pkg::coord_t x_q, x_d, y_q, y_d;
  sor_pkg::count_t cnt_q, cnt_d;
  sor_pkg::step_e  stx_q, stx_d, sty_q, sty_d;
  logic [AddrW-1:0] clr_addr_q;

  logic load, issue, clear_we, last_cell, in_grid, rd_en;
  logic [AddrW-1:0] cell_addr;

  logic [sor_pkg::HitW-1:0] cells [Depth];
  logic [sor_pkg::HitW-1:0] rd_q, hit_new;
  logic                     s1_wr_q, s1_last_q;
  logic [AddrW-1:0]         s1_addr_q;

  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [sor_pkg::HitW-1:0] mem_wdata;

  sor_pkg::total_t total_q, total_d;
  logic            inc;

  assign last_cell = (cnt_q == sor_pkg::CountW'(1));
  assign load      = (state_q == sor_pkg::ST_IDLE) && cmd_valid_i && !res_full_i
                     && !s1_last_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sor_pkg::ST_CLEAR: begin
        if (clr_addr_q == {AddrW{1'b1}}) begin
          state_d = sor_pkg::ST_IDLE;
        end
      end
      sor_pkg::ST_IDLE: begin
        if (load) begin
          state_d = sor_pkg::ST_RUN;
        end
      end
      sor_pkg::ST_RUN: begin
        if (last_cell) begin
          state_d = sor_pkg::ST_IDLE;
        end
      end
      default: state_d = sor_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    issue      = 1'b0;
    clear_we   = 1'b0;
    clearing_o = 1'b0;
    unique case (state_q)
      sor_pkg::ST_CLEAR: begin
        clear_we   = 1'b1;
        clearing_o = 1'b1;
      end
      sor_pkg::ST_IDLE: cmd_pop_o = load;
      sor_pkg::ST_RUN:  issue     = 1'b1;
      default: ;
    endcase
  end

  // walker registers: load a command, then step once per cell
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    cnt_d = cnt_q;
    stx_d = stx_q;
    sty_d = sty_q;
    if (load) begin
      x_d   = cmd_i.x;
      y_d   = cmd_i.y;
      cnt_d = cmd_i.count;
      stx_d = cmd_i.step_x;
      sty_d = cmd_i.step_y;
    end else if (issue) begin
      cnt_d = cnt_q - sor_pkg::CountW'(1);
      case (stx_q)
        sor_pkg::STEP_INC: x_d = x_q + sor_pkg::CoordW'(1);
        sor_pkg::STEP_DEC: x_d = x_q - sor_pkg::CoordW'(1);
        default:           x_d = x_q;
      endcase
      case (sty_q)
        sor_pkg::STEP_INC: y_d = y_q + sor_pkg::CoordW'(1);
        sor_pkg::STEP_DEC: y_d = y_q - sor_pkg::CoordW'(1);
        default:           y_d = y_q;
      endcase
    end
  end

  // cells outside the grid are walked but not stored
  assign in_grid   = (32'(x_q) < 32'(GRID_SIDE)) && (32'(y_q) < 32'(GRID_SIDE));
  assign cell_addr = {x_q[AW-1:0], y_q[AW-1:0]};
  assign rd_en     = issue && in_grid;

  // update stage: saturating hit count, total bumps on one-to-two
  assign hit_new = (rd_q == sor_pkg::HIT_SAT) ? rd_q : rd_q + sor_pkg::HitW'(1);
  assign inc     = s1_wr_q && (rd_q == sor_pkg::HIT_ONE);
  assign total_d = (inc && (total_q != sor_pkg::TOTAL_MAX))
                   ? total_q + sor_pkg::TotalW'(1) : total_q;

  assign res_push_o  = s1_last_q;
  assign res_total_o = total_d;

  // shared write port: clearing sweep or hit update
  assign mem_we    = clear_we || s1_wr_q;
  assign mem_waddr = clear_we ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clear_we ? '0 : hit_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sor_pkg::ST_CLEAR;
      clr_addr_q <= '0;
      cnt_q      <= '0;
      s1_wr_q    <= 1'b0;
      s1_last_q  <= 1'b0;
      total_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      s1_wr_q   <= rd_en;
      s1_last_q <= issue && last_cell;
      total_q   <= total_d;
      if (clear_we) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    stx_q     <= stx_d;
    sty_q     <= sty_d;
    s1_addr_q <= cell_addr;
  end

  // hit count store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= cells[cell_addr];
    end
  end

endmodule

// File: rtl/segment_overlap_rasterizer_core.sv
// ----------------------------------------------------------------------------
// segment_overlap_rasterizer_core
// Marks grid cells along line segments and reports the running overlap count.
// ----------------------------------------------------------------------------
// Input channel: push / full with the two endpoints start_x/y, end_x/y.
// A word is taken on a clock edge with push high and full low.
// Result channel: empty / pop; overlap_points_o holds the oldest result
// while empty is low, one result per segment, in input order.
// A segment of n cells (n = span + 1 for straight lines, min(|dx|,|dy|) + 1
// for diagonals) is walked one cell at a time; the walker loads the next
// segment only after it has finished the current one.
// The walker does one hit-count read-modify-write per cycle while walking
// a segment, on a single read and single write port of the cell store.
// After reset the cell store is swept to zero, one cell per cycle, over
// all min(GRID_SIDE,1024) rounded up to a power of two, squared, cells
// (1,048,576 at the default); full stays high during the sweep.
// A stalled result side fills the result queue; the walker then holds new
// segments and the input side backs up into full.
// ----------------------------------------------------------------------------
`include "segment_overlap_rasterizer_core_assert.svh"

module segment_overlap_rasterizer_core #(
  parameter int GRID_SIDE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [sor_pkg::CoordW-1:0]         start_x_i,
  input  logic [sor_pkg::CoordW-1:0]         start_y_i,
  input  logic [sor_pkg::CoordW-1:0]         end_x_i,
  input  logic [sor_pkg::CoordW-1:0]         end_y_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [sor_pkg::TotalW-1:0]         overlap_points_o
);

  sor_pkg::seg_t   seg;
  sor_pkg::cmd_t   cmd_in, cmd_out;
  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic            res_push, res_full;
  sor_pkg::total_t res_total;
  logic            clearing;

  assign seg.sx = start_x_i;
  assign seg.sy = start_y_i;
  assign seg.ex = end_x_i;
  assign seg.ey = end_y_i;

  // input register and classification
  sor_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .seg_i      (seg),
    .hold_i     (clearing),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // command queue between classifier and walker
  sor_fifo #(
    .Width ($bits(sor_pkg::cmd_t)),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // cell walker with hit store and running total
  sor_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_total_o (res_total),
    .clearing_o  (clearing)
  );

  // result queue toward the consumer
  sor_fifo #(
    .Width (sor_pkg::TotalW),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_total),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (overlap_points_o),
    .empty_o (empty)
  );

  // checks
  `SOR_ASSERT_NEVER(a_res_overflow, clk_i, rst_ni, res_push && res_full)
  `SOR_ASSERT_NEVER(a_cmd_overflow, clk_i, rst_ni, cmd_push && cmd_full)
  `SOR_ASSERT_IMPLIES(a_no_take_in_clear, clk_i, rst_ni, clearing, full)
  `SOR_ASSERT_IMPLIES(a_load_has_room, clk_i, rst_ni, cmd_pop, !res_full && !clearing)

endmodule
